FILE: hdl/mtp_pkg.sv
package mtp_pkg;

  // Default contact table size
  localparam int unsigned NumSlotsDefault = 16;

  // Field widths
  localparam int unsigned TypeW   = 16;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned ActionW = 2;

  // Stream widths: input tdata = code + value, tuser = type
  localparam int unsigned InDataW  = CodeW + ValueW;
  localparam int unsigned InUserW  = TypeW;
  // Output tdata = action + x + y + reconnect, padded to whole bytes
  localparam int unsigned OutUsedW = ActionW + 2 * CoordW + 1;
  localparam int unsigned OutDataW = ((OutUsedW + 7) / 8) * 8;
  localparam int unsigned OutPadW  = OutDataW - OutUsedW;

  // Depth of the queue between decoder and executor
  localparam int unsigned QDepth = 2;

  // Linux input event numbering
  localparam logic [TypeW-1:0] EvtSyn      = 16'h0000;
  localparam logic [TypeW-1:0] EvtKey      = 16'h0001;
  localparam logic [TypeW-1:0] EvtAbs      = 16'h0003;
  localparam logic [CodeW-1:0] SyncReport  = 16'h0000;
  localparam logic [CodeW-1:0] SyncDropped = 16'h0003;
  localparam logic [CodeW-1:0] KeyTouch    = 16'h014a;
  localparam logic [CodeW-1:0] AxisX       = 16'h0000;
  localparam logic [CodeW-1:0] AxisY       = 16'h0001;
  localparam logic [CodeW-1:0] AxisSlot    = 16'h002f;
  localparam logic [CodeW-1:0] AxisMtX     = 16'h0035;
  localparam logic [CodeW-1:0] AxisMtY     = 16'h0036;
  localparam logic [CodeW-1:0] AxisTrack   = 16'h0039;

  // Decoded operation
  typedef enum logic [3:0] {
    OP_IGNORE,
    OP_DROP,
    OP_REPORT,
    OP_SET_X,
    OP_SET_Y,
    OP_SLOT,
    OP_TRACK,
    OP_MT_X,
    OP_MT_Y,
    OP_BUTTON
  } op_e;

  // Pointer action codes
  typedef enum logic [ActionW-1:0] {
    ACT_NONE,
    ACT_PRESS,
    ACT_MOVE,
    ACT_RELEASE
  } action_e;

  // Decoded command: flag is slot-in-range, contact-active or key-down
  typedef struct packed {
    op_e               op;
    logic              flag;
    logic [ValueW-1:0] value;
  } cmd_t;

endpackage

FILE: hdl/mtp_front.sv
module mtp_front #(
  parameter int unsigned NumSlots = mtp_pkg::NumSlotsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [mtp_pkg::TypeW-1:0]  ev_type_i,
  input  logic [mtp_pkg::CodeW-1:0]  ev_code_i,
  input  logic [mtp_pkg::ValueW-1:0] ev_value_i,
  output logic                    cmd_valid_o,
  input  logic                    cmd_ready_i,
  output mtp_pkg::cmd_t           cmd_o
);
  import mtp_pkg::*;

  cmd_t cmd_dec;
  logic vld_d, vld_q;
  cmd_t cmd_q;

  // Classify the event
  always_comb begin
    cmd_dec.op    = OP_IGNORE;
    cmd_dec.flag  = 1'b0;
    cmd_dec.value = ev_value_i;
    unique case (ev_type_i)
      EvtSyn: begin
        if (ev_code_i == SyncDropped) begin
          cmd_dec.op = OP_DROP;
        end else if (ev_code_i == SyncReport) begin
          cmd_dec.op = OP_REPORT;
        end
      end
      EvtKey: begin
        if (ev_code_i == KeyTouch) begin
          cmd_dec.op   = OP_BUTTON;
          cmd_dec.flag = |ev_value_i;
        end
      end
      EvtAbs: begin
        unique case (ev_code_i)
          AxisX:     cmd_dec.op = OP_SET_X;
          AxisY:     cmd_dec.op = OP_SET_Y;
          AxisSlot: begin
            cmd_dec.op   = OP_SLOT;
            cmd_dec.flag = ev_value_i < ValueW'(NumSlots);
          end
          AxisTrack: begin
            cmd_dec.op   = OP_TRACK;
            cmd_dec.flag = ~ev_value_i[ValueW-1];
          end
          AxisMtX:   cmd_dec.op = OP_MT_X;
          AxisMtY:   cmd_dec.op = OP_MT_Y;
          default:   cmd_dec.op = OP_IGNORE;
        endcase
      end
      default: cmd_dec.op = OP_IGNORE;
    endcase
  end

  // Decode register
  assign in_ready_o  = !vld_q || cmd_ready_i;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (cmd_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_dec;
    end
  end

endmodule

FILE: hdl/mtp_queue.sv
module mtp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  mtp_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output mtp_pkg::cmd_t pop_data_o
);
  import mtp_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cmd_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hdl/mtp_back.sv
module mtp_back #(
  parameter int unsigned NumSlots = mtp_pkg::NumSlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  mtp_pkg::cmd_t                 cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mtp_pkg::action_e              action_o,
  output logic signed [mtp_pkg::CoordW-1:0] x_o,
  output logic signed [mtp_pkg::CoordW-1:0] y_o,
  output logic                          reconnect_o
);
  import mtp_pkg::*;

  localparam int unsigned SlotW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  // Control state
  logic                drop_d, drop_q;
  logic                pressed_d, pressed_q;
  logic                button_d, button_q;
  logic                mt_d, mt_q;
  logic [SlotW-1:0]    cur_d, cur_q;
  logic                fol_vld_d, fol_vld_q;
  logic [SlotW-1:0]    fol_d, fol_q;
  logic [CoordW-1:0]   held_x_d, held_x_q, held_y_d, held_y_q;
  logic [NumSlots-1:0] act_d, act_q;
  logic [NumSlots-1:0] xv_d, xv_q, yv_d, yv_q;

  // Contact positions; an entry reads as zero until written
  logic [CoordW-1:0]   slot_x_q [NumSlots];
  logic [CoordW-1:0]   slot_y_q [NumSlots];
  logic                wr_x, wr_y;

  // Result register
  logic                out_vld_d, out_vld_q;
  action_e             act_res, act_res_q;
  logic [CoordW-1:0]   x_res, y_res, x_res_q, y_res_q;
  logic                rc_res, rc_res_q;

  logic                pop;
  logic [SlotW-1:0]    low_slot, sel_slot, slot_idx;
  logic                fol_keep, any_act, down;

  assign cmd_ready_o = !out_vld_q || out_ready_i;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign slot_idx    = cmd_i.value[SlotW-1:0];

  // Lowest active contact
  always_comb begin
    low_slot = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (act_q[i]) begin
        low_slot = SlotW'(i);
      end
    end
  end

  assign any_act  = |act_q;
  assign fol_keep = fol_vld_q && act_q[fol_q];
  assign sel_slot = fol_keep ? fol_q : low_slot;

  // Execute one command
  always_comb begin
    drop_d    = drop_q;
    pressed_d = pressed_q;
    button_d  = button_q;
    mt_d      = mt_q;
    cur_d     = cur_q;
    fol_vld_d = fol_vld_q;
    fol_d     = fol_q;
    held_x_d  = held_x_q;
    held_y_d  = held_y_q;
    act_d     = act_q;
    xv_d      = xv_q;
    yv_d      = yv_q;
    wr_x      = 1'b0;
    wr_y      = 1'b0;
    down      = 1'b0;
    act_res   = ACT_NONE;
    x_res     = '0;
    y_res     = '0;
    rc_res    = 1'b0;
    if (pop) begin
      if (cmd_i.op == OP_DROP) begin
        // Cancel everything, skip events up to the next report
        act_res   = pressed_q ? ACT_RELEASE : ACT_NONE;
        x_res     = held_x_q;
        y_res     = held_y_q;
        rc_res    = 1'b1;
        drop_d    = 1'b1;
        pressed_d = 1'b0;
        button_d  = 1'b0;
        mt_d      = 1'b0;
        cur_d     = '0;
        fol_vld_d = 1'b0;
        held_x_d  = '0;
        held_y_d  = '0;
        act_d     = '0;
        xv_d      = '0;
        yv_d      = '0;
      end else if (drop_q) begin
        if (cmd_i.op == OP_REPORT) begin
          drop_d = 1'b0;
        end
      end else begin
        unique case (cmd_i.op)
          OP_SET_X: held_x_d = cmd_i.value;
          OP_SET_Y: held_y_d = cmd_i.value;
          OP_SLOT: begin
            mt_d = 1'b1;
            if (cmd_i.flag) begin
              cur_d = slot_idx;
            end
          end
          OP_TRACK: begin
            mt_d         = 1'b1;
            act_d[cur_q] = cmd_i.flag;
            if (cmd_i.flag && !fol_vld_q) begin
              fol_vld_d = 1'b1;
              fol_d     = cur_q;
            end
          end
          OP_MT_X: begin
            mt_d        = 1'b1;
            wr_x        = 1'b1;
            xv_d[cur_q] = 1'b1;
          end
          OP_MT_Y: begin
            mt_d        = 1'b1;
            wr_y        = 1'b1;
            yv_d[cur_q] = 1'b1;
          end
          OP_BUTTON: button_d = cmd_i.flag;
          OP_REPORT: begin
            down = button_q;
            if (mt_q) begin
              // Keep the followed contact while active, else take the lowest
              fol_vld_d = any_act;
              fol_d     = sel_slot;
              down      = any_act;
              if (any_act) begin
                held_x_d = xv_q[sel_slot] ? slot_x_q[sel_slot] : '0;
                held_y_d = yv_q[sel_slot] ? slot_y_q[sel_slot] : '0;
              end
            end
            if (down) begin
              act_res   = pressed_q ? ACT_MOVE : ACT_PRESS;
              pressed_d = 1'b1;
            end else if (pressed_q) begin
              act_res   = ACT_RELEASE;
              pressed_d = 1'b0;
            end
            x_res = held_x_d;
            y_res = held_y_d;
          end
          default: ;
        endcase
      end
    end
  end

  // Output register handshake
  always_comb begin
    out_vld_d = out_vld_q;
    if (pop) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q    <= 1'b0;
      pressed_q <= 1'b0;
      button_q  <= 1'b0;
      mt_q      <= 1'b0;
      cur_q     <= '0;
      fol_vld_q <= 1'b0;
      fol_q     <= '0;
      held_x_q  <= '0;
      held_y_q  <= '0;
      act_q     <= '0;
      xv_q      <= '0;
      yv_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      drop_q    <= drop_d;
      pressed_q <= pressed_d;
      button_q  <= button_d;
      mt_q      <= mt_d;
      cur_q     <= cur_d;
      fol_vld_q <= fol_vld_d;
      fol_q     <= fol_d;
      held_x_q  <= held_x_d;
      held_y_q  <= held_y_d;
      act_q     <= act_d;
      xv_q      <= xv_d;
      yv_q      <= yv_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Contact position storage
  always_ff @(posedge clk_i) begin
    if (wr_x) begin
      slot_x_q[cur_q] <= cmd_i.value;
    end
    if (wr_y) begin
      slot_y_q[cur_q] <= cmd_i.value;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      act_res_q <= act_res;
      x_res_q   <= x_res;
      y_res_q   <= y_res;
      rc_res_q  <= rc_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign action_o    = act_res_q;
  assign x_o         = x_res_q;
  assign y_o         = y_res_q;
  assign reconnect_o = rc_res_q;

endmodule

FILE: hdl/multitouch_event_to_pointer_unit.sv
// An accepted input passes the decode register, the command queue and the
// result register in turn; one result per input item and one item per cycle
// while m_axis_tready is high. Each report resolves the followed contact with
// one priority encoder over the contact flags in the executor.
// Reset (rst_ni low, asynchronous) clears all tracking state and the queue;
// contact positions read as zero until written, no clearing pass is needed.
module multitouch_event_to_pointer_unit #(
  parameter int unsigned NumSlots = mtp_pkg::NumSlotsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: [15:0] event_code, [47:16] event_value
  input  logic [mtp_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: [15:0] event_type
  input  logic [mtp_pkg::InUserW-1:0]    s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: [1:0] touch_action, [33:2] touch_x, [65:34] touch_y,
  //        [66] reconnect_request, [71:67] zero
  output logic [mtp_pkg::OutDataW-1:0]   m_axis_tdata
);
  import mtp_pkg::*;

  logic              f_valid, f_ready;
  cmd_t              f_cmd;
  logic              q_valid, q_ready;
  cmd_t              q_cmd;
  action_e           touch_action;
  logic [CoordW-1:0] touch_x, touch_y;
  logic              reconnect_request;

  // Decoder
  mtp_front #(
    .NumSlots(NumSlots)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .ev_type_i   (s_axis_tuser[TypeW-1:0]),
    .ev_code_i   (s_axis_tdata[CodeW-1:0]),
    .ev_value_i  (s_axis_tdata[CodeW+ValueW-1:CodeW]),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  // Command queue
  mtp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  // Executor
  mtp_back #(
    .NumSlots(NumSlots)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .action_o    (touch_action),
    .x_o         (touch_x),
    .y_o         (touch_y),
    .reconnect_o (reconnect_request)
  );

  assign m_axis_tdata = {OutPadW'(0), reconnect_request, touch_y, touch_x, touch_action};

endmodule

FILE: hdl/mtp_checker.sv
module mtp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [mtp_pkg::InDataW-1:0]  s_axis_tdata,
  input logic [mtp_pkg::InUserW-1:0]  s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [mtp_pkg::OutDataW-1:0] m_axis_tdata
);
  import mtp_pkg::*;

  localparam int unsigned RcBit = OutUsedW - 1;

  logic [ActionW-1:0] out_action;
  logic               in_dropped;

  assign out_action = m_axis_tdata[ActionW-1:0];
  assign in_dropped = s_axis_tuser == EvtSyn && s_axis_tdata[CodeW-1:0] == SyncDropped;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Reset empties the result register
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // A reconnect result never presses or moves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[RcBit] |->
      out_action == ACT_NONE || out_action == ACT_RELEASE)
    else $error("reconnect result with press or move");

  // Padding bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:OutUsedW] == '0)
    else $error("padding bits set");

  // Accepting a dropped sync with nothing queued gives a reconnect result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && in_dropped && !m_axis_tvalid &&
    $past(!s_axis_tvalid, 1) && $past(!s_axis_tvalid, 2) && $past(!s_axis_tvalid, 3) &&
    $past(rst_ni, 3) && m_axis_tready ##1 !s_axis_tvalid && m_axis_tready
      ##1 !s_axis_tvalid && m_axis_tready
      |=> m_axis_tvalid && m_axis_tdata[RcBit])
    else $error("dropped sync without reconnect result");

endmodule

bind multitouch_event_to_pointer_unit mtp_checker u_mtp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
